// ===== rtl/bounded_fifo_mean_tracker_macros.svh =====
`ifndef BOUNDED_FIFO_MEAN_TRACKER_MACROS_SVH
`define BOUNDED_FIFO_MEAN_TRACKER_MACROS_SVH

// checked only while out of reset
`define BFMT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define BFMT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bfmt_pkg.sv =====
package bfmt_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int ID_W        = 12;
  localparam int HEIGHT_W    = 9;
  localparam int MEAN_W      = 9;
  localparam int LIMIT_W     = 3;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = HEIGHT_W + $clog2(QUEUE_DEPTH);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [ID_W-1:0]     player_id;
    logic [HEIGHT_W-1:0] player_height;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0]   mean_height;
    logic [ID_W-1:0]     removed_id;
    logic [HEIGHT_W-1:0] removed_height;
    logic                remove_error;
  } out_item_t;

endpackage

// ===== rtl/bounded_fifo_mean_tracker.sv =====
// Bounded queue of (id, height) records with a running mean height. A command
// is taken when start is high and busy is low; its single result appears on
// out_data for exactly one cycle with out_valid, and the receiver cannot stall
// it, so it must sample on that cycle. No new command is taken while busy. A
// remove updates the queue in ST_EXEC. An insert updates the queue and the
// running sum in ST_EXEC, then a restoring divider in ST_DIV produces one
// quotient bit per cycle over the SUM_W bits of the sum, and ST_ROUND
// rounds to nearest, ties to even. The eviction limit is written through the
// cfg channel, which is always ready.
module bounded_fifo_mean_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  bfmt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output bfmt_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bfmt_pkg::LIMIT_W-1:0]        cfg_data
);

  localparam int PTR_W = bfmt_pkg::PTR_W;
  localparam int CNT_W = bfmt_pkg::CNT_W;
  localparam int SUM_W = bfmt_pkg::SUM_W;
  localparam int BIT_W = $clog2(SUM_W + 1);
  localparam int CMP_W = (CNT_W > bfmt_pkg::LIMIT_W + 1) ? CNT_W : bfmt_pkg::LIMIT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_ROUND
  } state_t;

  state_t                            state_r, state_nxt;
  logic                              op_r, op_nxt;
  logic [bfmt_pkg::ID_W-1:0]         pid_r, pid_nxt;
  logic [bfmt_pkg::HEIGHT_W-1:0]     ph_r, ph_nxt;
  logic [bfmt_pkg::ID_W-1:0]         hid_r;
  logic [bfmt_pkg::HEIGHT_W-1:0]     hh_r;
  logic [PTR_W-1:0]                  head_r, head_nxt;
  logic [PTR_W-1:0]                  tail_r, tail_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [SUM_W-1:0]                  sum_r, sum_nxt;
  logic [bfmt_pkg::LIMIT_W-1:0]      limit_r, limit_nxt;
  logic [SUM_W-1:0]                  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]                  rem_r, rem_nxt;
  logic [BIT_W-1:0]                  bit_r, bit_nxt;
  logic                              out_valid_r, out_valid_nxt;
  bfmt_pkg::out_item_t               out_r, out_nxt;

  logic [bfmt_pkg::ID_W-1:0]         id_store [bfmt_pkg::QUEUE_DEPTH];
  logic [bfmt_pkg::HEIGHT_W-1:0]     height_store [bfmt_pkg::QUEUE_DEPTH];

  logic                              accept;
  logic                              mem_we;
  logic [CMP_W-1:0]                  limit_bound;
  logic [CMP_W-1:0]                  bound;
  logic                              evict;
  logic [CNT_W:0]                    rem_sh;
  logic                              q_bit;
  logic [CNT_W:0]                    rem_twice;
  logic                              round_up;
  logic [SUM_W-1:0]                  q_rounded;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(bfmt_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
  assign mem_we    = (state_r == ST_EXEC) && (op_r == bfmt_pkg::OP_INSERT);

  assign limit_bound = CMP_W'(limit_r) + CMP_W'(1);
  assign bound       = (limit_bound > CMP_W'(bfmt_pkg::QUEUE_DEPTH)) ?
                       CMP_W'(bfmt_pkg::QUEUE_DEPTH) : limit_bound;
  assign evict       = (CMP_W'(count_r) >= bound) && (count_r != '0);

  assign rem_sh    = {rem_r, dvd_r[SUM_W-1]};
  assign q_bit     = (rem_sh >= {1'b0, count_r});
  assign rem_twice = {rem_r, 1'b0};
  assign round_up  = (rem_twice > {1'b0, count_r}) ||
                     ((rem_twice == {1'b0, count_r}) && dvd_r[0]);
  assign q_rounded = dvd_r + SUM_W'(round_up);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pid_nxt       = pid_r;
    ph_nxt        = ph_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    limit_nxt     = limit_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    if (cfg_valid) begin
      limit_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt    = in_data.operation;
          pid_nxt   = in_data.player_id;
          ph_nxt    = in_data.player_height;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == bfmt_pkg::OP_INSERT) begin
          head_nxt  = evict ? ptr_inc(head_r) : head_r;
          tail_nxt  = ptr_inc(tail_r);
          count_nxt = evict ? count_r : count_r + CNT_W'(1);
          sum_nxt   = sum_r - (evict ? SUM_W'(hh_r) : '0) + SUM_W'(ph_r);
          dvd_nxt   = sum_nxt;
          rem_nxt   = '0;
          bit_nxt   = BIT_W'(SUM_W);
          state_nxt = ST_DIV;
        end else begin
          out_nxt = '0;
          if (count_r == '0) begin
            out_nxt.remove_error = 1'b1;
          end else begin
            head_nxt               = ptr_inc(head_r);
            count_nxt              = count_r - CNT_W'(1);
            sum_nxt                = sum_r - SUM_W'(hh_r);
            out_nxt.removed_id     = hid_r;
            out_nxt.removed_height = hh_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV: begin
        rem_nxt = q_bit ? CNT_W'(rem_sh - {1'b0, count_r}) : CNT_W'(rem_sh);
        dvd_nxt = {dvd_r[SUM_W-2:0], q_bit};
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == BIT_W'(1)) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        out_nxt             = '0;
        out_nxt.mean_height = q_rounded[bfmt_pkg::MEAN_W-1:0];
        out_valid_nxt       = 1'b1;
        state_nxt           = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      limit_r     <= bfmt_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r  <= op_nxt;
    pid_r <= pid_nxt;
    ph_r  <= ph_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    out_r <= out_nxt;
  end

  // head entry is fetched on accept, tail entry written while executing an insert
  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_store[tail_r]     <= pid_r;
      height_store[tail_r] <= ph_r;
    end
    if (accept) begin
      hid_r <= id_store[head_r];
      hh_r  <= height_store[head_r];
    end
  end

endmodule

// ===== rtl/bfmt_checker.sv =====
`include "bounded_fifo_mean_tracker_macros.svh"

module bfmt_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input bfmt_pkg::out_item_t  out_data
);

  `BFMT_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted transaction did not raise busy")
  `BFMT_ASSERT(a_strobe_single, clk, rst_n, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `BFMT_ASSERT(a_result_after_busy, clk, rst_n, out_valid |-> $past(busy), "result without a transaction in flight")
  `BFMT_ASSERT(a_error_clean, clk, rst_n, (out_valid && out_data.remove_error) |-> (out_data.removed_id == '0 && out_data.removed_height == '0 && out_data.mean_height == '0), "error result carries data")
  `BFMT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule

bind bounded_fifo_mean_tracker bfmt_checker u_bfmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
